@@ rtl/utf8pn_pkg.sv @@
// Shared types and constants for the UTF-8 punctuation normaliser.
// Holds the port structs, the burst record passed through the queue, and sizing constants.
// No dependencies.
package utf8pn_pkg;

	// Most result bytes a single input byte can release: a replacement of three
	// bytes followed by two trailing held bytes.
	localparam int MaxBytes = 5;
	localparam int LenW = $clog2(MaxBytes + 1);

	// Default number of bursts the queue between front and back can hold.
	localparam int DefaultQueueDepth = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// The result bytes released by one accepted input byte.
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [LenW-1:0]          len;
		logic                     last;
	} burst_t;

endpackage

@@ rtl/utf8pn_front.sv @@
// Front end of the normaliser: holds lookahead bytes and decides each E2 80 xx triple.
// Produces at most one burst of result bytes per accepted input byte.
// Depends on utf8pn_pkg.
module utf8pn_front import utf8pn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic     accept,
	output burst_t   burst,
	output logic     burst_valid
);

	localparam int HeldMax = 4;

	localparam logic [7:0] LeadByte = 8'hE2;
	localparam logic [7:0] MidByte  = 8'h80;
	localparam logic [7:0] EnDash   = 8'h93;
	localparam logic [7:0] EmDash   = 8'h94;
	localparam logic [7:0] LSquote  = 8'h98;
	localparam logic [7:0] RSquote  = 8'h99;
	localparam logic [7:0] LDquote  = 8'h9C;
	localparam logic [7:0] RDquote  = 8'h9D;
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChDash   = 8'h2D;
	localparam logic [7:0] ChApos   = 8'h27;
	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChS      = 8'h73;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	logic [7:0] win_q [HeldMax];
	logic [2:0] cnt_q;
	logic [7:0] bbl_q;

	logic [7:0] win_d [HeldMax];
	logic [2:0] cnt_d;
	logic [7:0] bbl_d;

	logic [7:0] w [MaxBytes];
	logic [2:0] n, need, r, k, rlen;
	logic [7:0] repl0, repl1, repl2, nxt;
	logic       is_mid;

	// Window as it stands with the new byte appended.
	always_comb begin
		for (int i = 0; i < HeldMax; i++) begin
			w[i] = (3'(i) < cnt_q) ? win_q[i] : item.in_byte;
		end
		w[HeldMax] = item.in_byte;
		n = cnt_q + 3'd1;
	end

	// Classify the held triple and pick its replacement.
	always_comb begin
		is_mid = (n >= 3'd3) && (w[1] == MidByte);
		need = 3'd3;
		if (is_mid && w[2] == EnDash) begin
			need = 3'd4;
		end else if (is_mid && w[2] == RSquote) begin
			need = 3'd5;
		end
		nxt = (n >= 3'd4) ? w[3] : 8'h00;

		repl0 = w[0];
		repl1 = w[1];
		repl2 = w[2];
		rlen  = 3'd3;
		if (w[1] == MidByte) begin
			case (w[2])
				EnDash: begin
					if (is_digit(bbl_q) && is_digit(nxt)) begin
						repl0 = ChDash;
						rlen  = 3'd1;
					end else begin
						repl0 = ChSpace; repl1 = ChDash; repl2 = ChSpace;
					end
				end
				EmDash: begin
					repl0 = ChSpace; repl1 = ChDash; repl2 = ChSpace;
				end
				LSquote: begin
					repl0 = ChSpace; repl1 = ChApos; repl2 = ChSpace;
				end
				LDquote, RDquote: begin
					repl0 = ChSpace; repl1 = ChQuote; repl2 = ChSpace;
				end
				RSquote: begin
					repl0 = ChSpace; repl1 = ChApos; repl2 = ChSpace;
					if (n == 3'd5 && w[3] == ChS && w[4] == ChSpace) begin
						rlen = 3'd2;
					end
				end
				default: begin
					repl0 = w[0]; repl1 = w[1]; repl2 = w[2];
				end
			endcase
		end

		// Bytes behind the triple are rescanned: leading plain bytes go out,
		// a new lead and whatever follows it stay held unless the buffer ends.
		r = n - 3'd3;
		k = 3'd0;
		if (item.in_last) begin
			k = r;
		end else if (r >= 3'd1 && w[3] != LeadByte) begin
			k = 3'd1;
			if (r >= 3'd2 && w[4] != LeadByte) begin
				k = 3'd2;
			end
		end
	end

	always_comb begin
		burst       = '0;
		cnt_d       = cnt_q;
		bbl_d       = bbl_q;
		for (int i = 0; i < HeldMax; i++) begin
			win_d[i] = win_q[i];
		end

		if (cnt_q == 3'd0 && item.in_byte != LeadByte) begin
			burst.bytes[0] = item.in_byte;
			burst.len      = LenW'(1);
			bbl_d          = item.in_byte;
		end else if (n < need && !item.in_last) begin
			for (int i = 0; i < HeldMax; i++) begin
				win_d[i] = w[i];
			end
			cnt_d = n;
		end else if (n < 3'd3) begin
			// A short tail at the end of the buffer goes out unchanged.
			burst.bytes[0] = w[0];
			burst.bytes[1] = w[1];
			burst.len      = LenW'(n);
			cnt_d          = 3'd0;
		end else begin
			case (rlen)
				3'd1: burst.bytes = {8'h00, 8'h00, w[4], w[3], repl0};
				3'd2: burst.bytes = {8'h00, w[4], w[3], repl1, repl0};
				default: burst.bytes = {w[4], w[3], repl2, repl1, repl0};
			endcase
			burst.len = LenW'(rlen + k);
			case (k)
				3'd0: bbl_d = w[2];
				3'd1: bbl_d = w[3];
				default: bbl_d = w[4];
			endcase
			cnt_d    = r - k;
			win_d[0] = (k == 3'd0) ? w[3] : w[4];
			win_d[1] = w[4];
		end

		if (item.in_last) begin
			burst.last = 1'b1;
			cnt_d      = 3'd0;
			bbl_d      = 8'h00;
		end
	end

	assign burst_valid = accept && (burst.len != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			bbl_q <= 8'h00;
		end else if (accept) begin
			cnt_q <= cnt_d;
			bbl_q <= bbl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < HeldMax; i++) begin
				win_q[i] <= win_d[i];
			end
		end
	end

endmodule

@@ rtl/utf8pn_fifo.sv @@
// Short queue of bursts between the front end and the back end.
// Register based, one write and one read port.
// Depends on utf8pn_pkg.
module utf8pn_fifo import utf8pn_pkg::*; #(
	parameter int Depth = DefaultQueueDepth
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  burst_t wr_data,
	output logic   full,
	input  logic   rd_en,
	output burst_t rd_data,
	output logic   empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	burst_t          mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr, do_rd;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ rtl/utf8pn_back.sv @@
// Back end of the normaliser: takes bursts from the queue and hands out their bytes one a beat.
// The current burst sits in a register that drives the result port.
// Depends on utf8pn_pkg.
module utf8pn_back import utf8pn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  burst_t    head,
	input  logic      head_valid,
	output logic      head_take,
	output out_item_t result,
	output logic      empty,
	input  logic      pop
);

	burst_t          cur_q;
	logic            valid_q;
	logic [LenW-1:0] idx_q;
	logic            at_end;

	assign at_end    = (idx_q == cur_q.len - LenW'(1));
	assign head_take = head_valid && (!valid_q || (pop && at_end));
	assign empty     = !valid_q;

	assign result.out_byte = cur_q.bytes[idx_q];
	assign result.out_last = cur_q.last && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (head_take) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (pop && valid_q) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + LenW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_take) begin
			cur_q <= head;
		end
	end

endmodule

@@ rtl/utf8_punctuation_normalizer.sv @@
// Top level of the UTF-8 punctuation normaliser.
// Instantiates utf8pn_front, utf8pn_fifo and utf8pn_back; depends on utf8pn_pkg.
//
// This block takes a text stream one byte a beat, with the final byte of each
// buffer marked, and rewrites the three-byte punctuation sequences that start
// E2 80 into plain ASCII: dashes, single and double curly quotes. Bytes from a
// lead E2 onward are held until enough lookahead has arrived to decide, so a
// result byte can appear several input beats after the byte that caused it;
// everything held is flushed on the marked final byte, which always produces
// at least one result carrying out_last. Both sides behave as queues: push an
// input beat while full is low, and pop a result beat while empty is low. The
// front end accepts one byte per clock while full is low and turns it into a
// burst of zero to five result bytes in the same cycle; bursts wait in a queue
// of QueueDepth entries, and the back end hands them out one byte per clock
// while pop is high. Input is therefore taken at one byte a cycle as long as
// the output side keeps up; when replacements expand the text, the single-byte
// result port sets the pace and full rises once the queue has filled. A released
// byte is written into the queue and then into the back end's register before it
// is visible on the result port.
module utf8_punctuation_normalizer import utf8pn_pkg::*; #(
	parameter int QueueDepth = DefaultQueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	burst_t burst, head;
	logic   accept, burst_valid, head_take, queue_empty;

	// An input beat is taken whenever the queue has room; a byte that releases
	// no result still updates the front end's window.
	assign accept = push && !full;

	utf8pn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.accept      (accept),
		.burst       (burst),
		.burst_valid (burst_valid)
	);

	utf8pn_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (burst_valid),
		.wr_data (burst),
		.full    (full),
		.rd_en   (head_take),
		.rd_data (head),
		.empty   (queue_empty)
	);

	utf8pn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!queue_empty),
		.head_take  (head_take),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
